FILE: rtl/vogrs_pkg.sv
`default_nettype none
package vogrs_pkg;

  localparam int DIM_MAX_DEF     = 32;
  localparam int CELL_BITS_DEF   = 8;
  localparam int MAX_RESULTS_DEF = 64;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SIZE_X   = 3'd0,
    CFG_SIZE_Y   = 3'd1,
    CFG_SIZE_Z   = 3'd2,
    CFG_OCC_THR  = 3'd3,
    CFG_CELL_MAX = 3'd4,
    CFG_CELL_MIN = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_FILL   = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    S_FILL,
    S_IDLE,
    S_PREP,
    S_UPD_ADDR,
    S_UPD_RD,
    S_UPD_WR,
    S_SHELL,
    S_COL,
    S_VADDR,
    S_VRD,
    S_VEVAL,
    S_NEXT,
    S_FLUSH
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/vogrs_ram.sv
`default_nettype none
module vogrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/voxel_occupancy_grid_radius_search_top.sv
`default_nettype none
// 3D log-odds occupancy grid with a cell-radius search.
// Input channel in_*: one item per command; in_tuser carries the kind (update,
// fill, search), in_tdata the cell, value, radius and point limit.
// Result channel out_*: one item per hit of a search, in shell order, x then y
// then z; out_tlast marks the final hit of a search. Update, fill and a search
// without hits give no result item.
// Configuration port cfg_*: one register write per cycle with cfg_we high.
// Sequence: an update is one read-modify-write of the voxel memory. A fill
// writes all DIM_MAX^3 voxels, one voxel written per cycle. A search runs a
// setup step, then S_SHELL per shell, S_COL per column (an empty column goes
// to S_NEXT) and S_VADDR, S_VRD, S_VEVAL, S_NEXT per visited voxel, then a
// flush; a zero radius ends after setup. The single voxel memory port sets
// this pace. in_tready is high only while no item is in work.
// Reset: the voxel memory is cleared to zero by a pass over all DIM_MAX^3 voxels
// (32768 at the default size), during which in_tready stays low.
// A stalled receiver holds the search in its current voxel until the output
// register frees; no hit is dropped.
module voxel_occupancy_grid_radius_search_top
  import vogrs_pkg::*;
#(
  parameter int DIM_MAX     = DIM_MAX_DEF,
  parameter int CELL_BITS   = CELL_BITS_DEF,
  parameter int MAX_RESULTS = MAX_RESULTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // cell_x, cell_y, cell_z, log_odds_value, radius_cells, max_points, zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // kind
  input  wire logic [1:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // hit_valid, hit_x, hit_y, hit_z, cell_index, dist_sq, overflow, zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH = DIM_MAX * DIM_MAX * DIM_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(DIM_MAX + 1);
  localparam int DW    = $clog2(DIM_MAX + 64) + 1;
  localparam int D2W   = 2 * DW + 4;
  localparam int CNTW  = $clog2(MAX_RESULTS + 1);

  function automatic logic [SW-1:0] eff_size(input logic [5:0] v);
    logic [SW-1:0] e;
    if (v == 6'd0) begin
      e = SW'(1);
    end else if (int'(v) > DIM_MAX) begin
      e = SW'(DIM_MAX);
    end else begin
      e = SW'(v);
    end
    return e;
  endfunction

  function automatic logic signed [DW-1:0] ext6(input logic [5:0] v);
    return $signed({{(DW-6){1'b0}}, v});
  endfunction

  state_t state_r, state_nxt;

  logic [5:0] size_x_r, size_y_r, size_z_r;
  logic signed [7:0] thr_r, cmin_r;
  logic [6:0] cmax_r;

  logic [1:0] knd_r, knd_nxt;
  logic signed [DW-1:0] qx_r, qy_r, qz_r, qx_nxt, qy_nxt, qz_nxt;
  logic signed [7:0] val_r, val_nxt;
  logic [5:0] rad_r, rad_nxt;
  logic [6:0] maxp_r, maxp_nxt;
  logic [AW-1:0] sxy_r, sxy_nxt;
  logic [11:0] r2_r, r2_nxt;
  logic signed [DW-1:0] s_r, s_nxt, x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [DW-1:0] x1_r, x1_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  logic signed [DW-1:0] z0_r, z0_nxt, z1_r, z1_nxt, zend_r, zend_nxt, zstep_r, zstep_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [D2W-1:0] d2_r, d2_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic over_r, over_nxt;
  logic pend_v_r, pend_v_nxt;
  logic [4:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic [14:0] pidx_r, pidx_nxt;
  logic [11:0] pd2_r, pd2_nxt;
  logic out_tvalid_r, out_tvalid_nxt, out_last_r, out_last_nxt, out_ovf_r, out_ovf_nxt;
  logic [4:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt, out_z_r, out_z_nxt;
  logic [14:0] out_idx_r, out_idx_nxt;
  logic [11:0] out_d2_r, out_d2_nxt;
  logic [AW-1:0] fcnt_r, fcnt_nxt;
  logic [CELL_BITS-1:0] fill_val_r, fill_val_nxt;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [CELL_BITS-1:0] ram_wdata, ram_rdata;

  logic [SW-1:0] sx, sy, sz;
  logic signed [DW-1:0] sxs, sys, szs;
  logic signed [DW:0] dx, dy, dz;
  logic signed [2*DW+1:0] sqx, sqy, sqz;
  logic signed [CELL_BITS:0] sum;
  logic signed [CELL_BITS-1:0] vox_val;
  logic out_free, hit;
  logic signed [DW-1:0] zlo, zhi, lo_b, hi_b;

  assign sx  = eff_size(size_x_r);
  assign sy  = eff_size(size_y_r);
  assign sz  = eff_size(size_z_r);
  assign sxs = $signed({{(DW-SW){1'b0}}, sx});
  assign sys = $signed({{(DW-SW){1'b0}}, sy});
  assign szs = $signed({{(DW-SW){1'b0}}, sz});

  assign dx  = (DW+1)'(x_r) - (DW+1)'(qx_r);
  assign dy  = (DW+1)'(y_r) - (DW+1)'(qy_r);
  assign dz  = (DW+1)'(z_r) - (DW+1)'(qz_r);
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign sqz = dz * dz;

  assign vox_val  = $signed(ram_rdata);
  assign out_free = !out_tvalid_r || out_tready;
  assign hit      = (vox_val < CELL_BITS'(thr_r)) && (d2_r <= D2W'(r2_r));
  assign zlo      = qz_r - s_r;
  assign zhi      = qz_r + s_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0, out_ovf_r, out_d2_r, out_idx_r, out_z_r, out_y_r, out_x_r, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= 6'd32;
      size_y_r <= 6'd32;
      size_z_r <= 6'd32;
      thr_r    <= 8'sd0;
      cmax_r   <= 7'd127;
      cmin_r   <= -8'sd127;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SIZE_X:   size_x_r <= cfg_wdata[5:0];
        CFG_SIZE_Y:   size_y_r <= cfg_wdata[5:0];
        CFG_SIZE_Z:   size_z_r <= cfg_wdata[5:0];
        CFG_OCC_THR:  thr_r    <= $signed(cfg_wdata);
        CFG_CELL_MAX: cmax_r   <= cfg_wdata[6:0];
        CFG_CELL_MIN: cmin_r   <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_FILL;
      fcnt_r       <= '0;
      fill_val_r   <= '0;
      cnt_r        <= '0;
      over_r       <= 1'b0;
      pend_v_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fcnt_r       <= fcnt_nxt;
      fill_val_r   <= fill_val_nxt;
      cnt_r        <= cnt_nxt;
      over_r       <= over_nxt;
      pend_v_r     <= pend_v_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    knd_r <= knd_nxt;   qx_r <= qx_nxt;   qy_r <= qy_nxt;   qz_r <= qz_nxt;
    val_r <= val_nxt;   rad_r <= rad_nxt; maxp_r <= maxp_nxt;
    sxy_r <= sxy_nxt;   r2_r <= r2_nxt;   s_r <= s_nxt;
    x_r <= x_nxt;       y_r <= y_nxt;     z_r <= z_nxt;
    x1_r <= x1_nxt;     y0_r <= y0_nxt;   y1_r <= y1_nxt;
    z0_r <= z0_nxt;     z1_r <= z1_nxt;   zend_r <= zend_nxt; zstep_r <= zstep_nxt;
    addr_r <= addr_nxt; d2_r <= d2_nxt;
    px_r <= px_nxt;     py_r <= py_nxt;   pz_r <= pz_nxt;
    pidx_r <= pidx_nxt; pd2_r <= pd2_nxt;
    out_x_r <= out_x_nxt; out_y_r <= out_y_nxt; out_z_r <= out_z_nxt;
    out_idx_r <= out_idx_nxt; out_d2_r <= out_d2_nxt;
    out_last_r <= out_last_nxt; out_ovf_r <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    knd_nxt = knd_r;   qx_nxt = qx_r;   qy_nxt = qy_r;   qz_nxt = qz_r;
    val_nxt = val_r;   rad_nxt = rad_r; maxp_nxt = maxp_r;
    sxy_nxt = sxy_r;   r2_nxt = r2_r;   s_nxt = s_r;
    x_nxt = x_r;       y_nxt = y_r;     z_nxt = z_r;
    x1_nxt = x1_r;     y0_nxt = y0_r;   y1_nxt = y1_r;
    z0_nxt = z0_r;     z1_nxt = z1_r;   zend_nxt = zend_r; zstep_nxt = zstep_r;
    addr_nxt = addr_r; d2_nxt = d2_r;
    cnt_nxt = cnt_r;   over_nxt = over_r; pend_v_nxt = pend_v_r;
    px_nxt = px_r;     py_nxt = py_r;   pz_nxt = pz_r;
    pidx_nxt = pidx_r; pd2_nxt = pd2_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_x_nxt = out_x_r; out_y_nxt = out_y_r; out_z_nxt = out_z_r;
    out_idx_nxt = out_idx_r; out_d2_nxt = out_d2_r;
    out_last_nxt = out_last_r; out_ovf_nxt = out_ovf_r;
    fcnt_nxt = fcnt_r; fill_val_nxt = fill_val_r;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = fill_val_r;
    sum = '0;
    lo_b = '0;
    hi_b = '0;

    case (state_r)
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fcnt_r;
        if (int'(fcnt_r) == DEPTH - 1) begin
          fcnt_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          fcnt_nxt = fcnt_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          knd_nxt   = in_tuser;
          qx_nxt    = ext6(in_tdata[5:0]);
          qy_nxt    = ext6(in_tdata[11:6]);
          qz_nxt    = ext6(in_tdata[17:12]);
          val_nxt   = $signed(in_tdata[25:18]);
          rad_nxt   = in_tdata[31:26];
          maxp_nxt  = in_tdata[38:32];
          state_nxt = S_PREP;
        end
      end

      S_PREP: begin
        sxy_nxt  = AW'(sx) * AW'(sy);
        r2_nxt   = {6'b0, rad_r} * {6'b0, rad_r};
        cnt_nxt  = '0;
        over_nxt = 1'b0;
        s_nxt    = '0;
        case (knd_r)
          KIND_UPDATE: begin
            if (qx_r >= sxs || qy_r >= sys || qz_r >= szs) begin
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_UPD_ADDR;
            end
          end
          KIND_FILL: begin
            fill_val_nxt = CELL_BITS'(val_r);
            fcnt_nxt     = '0;
            state_nxt    = S_FILL;
          end
          KIND_SEARCH: begin
            if (qx_r > sxs - DW'(1)) qx_nxt = sxs - DW'(1);
            if (qy_r > sys - DW'(1)) qy_nxt = sys - DW'(1);
            if (qz_r > szs - DW'(1)) qz_nxt = szs - DW'(1);
            state_nxt = (rad_r == 6'd0) ? S_IDLE : S_SHELL;
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      S_UPD_ADDR: begin
        addr_nxt  = AW'($unsigned(qx_r)) + AW'($unsigned(qy_r)) * AW'(sx)
                  + AW'($unsigned(qz_r)) * sxy_r;
        state_nxt = S_UPD_RD;
      end

      S_UPD_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_UPD_WR;
      end

      S_UPD_WR: begin
        sum = (CELL_BITS+1)'(vox_val) + (CELL_BITS+1)'(val_r);
        if (val_r > 8'sd0) begin
          if (sum > $signed({{(CELL_BITS-6){1'b0}}, cmax_r})) begin
            sum = $signed({{(CELL_BITS-6){1'b0}}, cmax_r});
          end
        end else begin
          if (sum < (CELL_BITS+1)'(cmin_r)) begin
            sum = (CELL_BITS+1)'(cmin_r);
          end
        end
        ram_we    = 1'b1;
        ram_wdata = sum[CELL_BITS-1:0];
        state_nxt = S_IDLE;
      end

      S_SHELL: begin
        lo_b   = qx_r - s_r;
        hi_b   = qx_r + s_r;
        x_nxt  = (lo_b < 0) ? '0 : lo_b;
        x1_nxt = (hi_b > sxs - DW'(1)) ? sxs - DW'(1) : hi_b;
        lo_b   = qy_r - s_r;
        hi_b   = qy_r + s_r;
        y_nxt  = (lo_b < 0) ? '0 : lo_b;
        y0_nxt = (lo_b < 0) ? '0 : lo_b;
        y1_nxt = (hi_b > sys - DW'(1)) ? sys - DW'(1) : hi_b;
        z0_nxt = (zlo < 0) ? '0 : zlo;
        z1_nxt = (zhi > szs - DW'(1)) ? szs - DW'(1) : zhi;
        state_nxt = S_COL;
      end

      S_COL: begin
        if (x_r == qx_r - s_r || x_r == qx_r + s_r || y_r == qy_r - s_r ||
            y_r == qy_r + s_r) begin
          z_nxt     = z0_r;
          zend_nxt  = z1_r;
          zstep_nxt = DW'(1);
          state_nxt = S_VADDR;
        end else if (zlo >= 0) begin
          z_nxt     = zlo;
          zend_nxt  = (zhi < szs) ? zhi : zlo;
          zstep_nxt = s_r + s_r;
          state_nxt = S_VADDR;
        end else if (zhi < szs) begin
          z_nxt     = zhi;
          zend_nxt  = zhi;
          state_nxt = S_VADDR;
        end else begin
          // empty column: mark it finished
          z_nxt     = zlo;
          zend_nxt  = zlo;
          state_nxt = S_NEXT;
        end
      end

      S_VADDR: begin
        addr_nxt  = AW'($unsigned(x_r)) + AW'($unsigned(y_r)) * AW'(sx)
                  + AW'($unsigned(z_r)) * sxy_r;
        d2_nxt    = D2W'($unsigned(sqx)) + D2W'($unsigned(sqy)) + D2W'($unsigned(sqz));
        state_nxt = S_VRD;
      end

      S_VRD: begin
        ram_re    = 1'b1;
        state_nxt = S_VEVAL;
      end

      S_VEVAL: begin
        if (!hit) begin
          state_nxt = S_NEXT;
        end else if (int'(cnt_r) >= MAX_RESULTS) begin
          over_nxt  = 1'b1;
          state_nxt = S_NEXT;
        end else if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_tvalid_nxt = 1'b1;
            out_x_nxt      = px_r;
            out_y_nxt      = py_r;
            out_z_nxt      = pz_r;
            out_idx_nxt    = pidx_r;
            out_d2_nxt     = pd2_r;
            out_last_nxt   = 1'b0;
            out_ovf_nxt    = 1'b0;
          end
          pend_v_nxt = 1'b1;
          px_nxt     = x_r[4:0];
          py_nxt     = y_r[4:0];
          pz_nxt     = z_r[4:0];
          pidx_nxt   = 15'(addr_r);
          pd2_nxt    = 12'(d2_r);
          cnt_nxt    = cnt_r + CNTW'(1);
          state_nxt  = S_NEXT;
        end
      end

      S_NEXT: begin
        if (z_r != zend_r) begin
          z_nxt     = z_r + zstep_r;
          state_nxt = S_VADDR;
        end else if (y_r != y1_r) begin
          y_nxt     = y_r + DW'(1);
          state_nxt = S_COL;
        end else if (x_r != x1_r) begin
          x_nxt     = x_r + DW'(1);
          y_nxt     = y0_r;
          state_nxt = S_COL;
        end else if (over_r || (maxp_r != 7'd0 && int'(cnt_r) >= int'(maxp_r)) ||
                     s_r == ext6(rad_r)) begin
          state_nxt = S_FLUSH;
        end else begin
          s_nxt     = s_r + DW'(1);
          state_nxt = S_SHELL;
        end
      end

      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_x_nxt      = px_r;
          out_y_nxt      = py_r;
          out_z_nxt      = pz_r;
          out_idx_nxt    = pidx_r;
          out_d2_nxt     = pd2_r;
          out_last_nxt   = 1'b1;
          out_ovf_nxt    = over_r;
          pend_v_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  vogrs_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .re      (ram_re),
    .rd_addr (addr_r),
    .rd_data (ram_rdata)
  );

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= MAX_RESULTS)
    else $error("hit count beyond limit");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !pend_v_r)
    else $error("held hit left while idle");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !ram_we)
    else $error("voxel write while idle");

  a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    over_r |-> int'(cnt_r) == MAX_RESULTS)
    else $error("overflow before limit");
`endif

endmodule
`default_nettype wire

FILE: tb/voxel_grid_checker.sv
`timescale 1ns / 1ps
module voxel_grid_checker
  import vogrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    hits_pending
);

  localparam int CELLS = DIM_MAX_DEF * DIM_MAX_DEF * DIM_MAX_DEF;

  typedef struct {
    logic        valid;
    logic [4:0]  x;
    logic [4:0]  y;
    logic [4:0]  z;
    logic [14:0] idx;
    logic [11:0] d2;
    logic        ovf;
    logic        last;
  } hit_t;

  logic signed [7:0] voxels [CELLS];
  logic [5:0]        size_x_q, size_y_q, size_z_q;
  logic signed [7:0] thr_q, cmin_q;
  logic [6:0]        cmax_q;
  hit_t              expected_hits [$];

  int qx, qy, qz, r2, esx, esy, hit_cnt;
  bit overflowed;

  assign hits_pending = expected_hits.size();

  function automatic int eff_size(logic [5:0] s);
    if (s == 0) return 1;
    if (s > DIM_MAX_DEF) return DIM_MAX_DEF;
    return int'(s);
  endfunction

  function automatic void probe_voxel(int x, int y, int z);
    int a, d2;
    hit_t h;
    a = x + y * esx + z * esx * esy;
    d2 = (x - qx) * (x - qx) + (y - qy) * (y - qy) + (z - qz) * (z - qz);
    if (a < 0 || a >= CELLS) return;
    if (!(voxels[a] < thr_q) || d2 > r2) return;
    if (hit_cnt >= MAX_RESULTS_DEF) begin
      overflowed = 1'b1;
      return;
    end
    h.valid = 1'b1;
    h.x = x[4:0];
    h.y = y[4:0];
    h.z = z[4:0];
    h.idx = a[14:0];
    h.d2 = d2[11:0];
    h.ovf = 1'b0;
    h.last = 1'b0;
    expected_hits = {expected_hits, h};
    hit_cnt++;
  endfunction

  function automatic void predict_search(logic [IN_DATA_W-1:0] d);
    int sz, r, maxp, s, x, y, z, x0, x1, y0, y1, z0, z1;
    esx = eff_size(size_x_q);
    esy = eff_size(size_y_q);
    sz = eff_size(size_z_q);
    r = int'(d[31:26]);
    maxp = int'(d[38:32]);
    if (r == 0) return;
    qx = int'(d[5:0]);   if (qx > esx - 1) qx = esx - 1;
    qy = int'(d[11:6]);  if (qy > esy - 1) qy = esy - 1;
    qz = int'(d[17:12]); if (qz > sz - 1) qz = sz - 1;
    r2 = r * r;
    hit_cnt = 0;
    overflowed = 1'b0;
    for (s = 0; s <= r; s++) begin
      x0 = (qx - s < 0) ? 0 : qx - s;  x1 = (qx + s > esx - 1) ? esx - 1 : qx + s;
      y0 = (qy - s < 0) ? 0 : qy - s;  y1 = (qy + s > esy - 1) ? esy - 1 : qy + s;
      z0 = (qz - s < 0) ? 0 : qz - s;  z1 = (qz + s > sz - 1) ? sz - 1 : qz + s;
      for (x = x0; x <= x1; x++) begin
        for (y = y0; y <= y1; y++) begin
          if ((x - qx == s) || (qx - x == s) || (y - qy == s) || (qy - y == s)) begin
            for (z = z0; z <= z1; z++) probe_voxel(x, y, z);
          end else begin
            if (qz - s >= 0) probe_voxel(x, y, qz - s);
            if (s > 0 && qz + s < sz) probe_voxel(x, y, qz + s);
          end
        end
      end
      if (overflowed) break;
      if (maxp != 0 && hit_cnt >= maxp) break;
    end
    if (hit_cnt > 0) begin
      expected_hits[expected_hits.size() - 1].ovf = overflowed;
      expected_hits[expected_hits.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void apply_item(logic [1:0] kind, logic [IN_DATA_W-1:0] d);
    int x, y, z, a, sum, v;
    v = int'($signed(d[25:18]));
    x = int'(d[5:0]);
    y = int'(d[11:6]);
    z = int'(d[17:12]);
    case (kind)
      KIND_UPDATE: begin
        if (x < eff_size(size_x_q) && y < eff_size(size_y_q) && z < eff_size(size_z_q)) begin
          a = x + y * eff_size(size_x_q) + z * eff_size(size_x_q) * eff_size(size_y_q);
          sum = int'(voxels[a]) + v;
          if (v > 0) begin
            if (sum > int'(cmax_q)) sum = int'(cmax_q);
          end else begin
            if (sum < int'(cmin_q)) sum = int'(cmin_q);
          end
          voxels[a] = sum[7:0];
        end
      end
      KIND_FILL: foreach (voxels[i]) voxels[i] = v[7:0];
      KIND_SEARCH: predict_search(d);
      default: ;
    endcase
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    hit_t h;
    if (!rst_n) begin
      foreach (voxels[i]) voxels[i] = '0;
      size_x_q = 6'd32; size_y_q = 6'd32; size_z_q = 6'd32;
      thr_q = '0; cmax_q = 7'd127; cmin_q = -8'sd127;
      expected_hits.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SIZE_X:   size_x_q = cfg_wdata[5:0];
          CFG_SIZE_Y:   size_y_q = cfg_wdata[5:0];
          CFG_SIZE_Z:   size_z_q = cfg_wdata[5:0];
          CFG_OCC_THR:  thr_q = cfg_wdata;
          CFG_CELL_MAX: cmax_q = cfg_wdata[6:0];
          CFG_CELL_MIN: cmin_q = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) apply_item(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_hits.size() == 0) begin
          report("unexpected item", out_tdata[30:16], -1);
        end else begin
          h = expected_hits.pop_front();
          if (out_tdata[0] !== h.valid) report("hit_valid", out_tdata[0], h.valid);
          if (out_tdata[5:1] !== h.x) report("hit_x", out_tdata[5:1], h.x);
          if (out_tdata[10:6] !== h.y) report("hit_y", out_tdata[10:6], h.y);
          if (out_tdata[15:11] !== h.z) report("hit_z", out_tdata[15:11], h.z);
          if (out_tdata[30:16] !== h.idx) report("cell_index", out_tdata[30:16], h.idx);
          if (out_tdata[42:31] !== h.d2) report("distance", out_tdata[42:31], h.d2);
          if (out_tdata[43] !== h.ovf) report("overflow", out_tdata[43], h.ovf);
          if (out_tlast !== h.last) report("last", out_tlast, h.last);
        end
      end
    end
  end

endmodule

FILE: tb/voxel_occupancy_grid_radius_search_top_tb.sv
`timescale 1ns / 1ps
module voxel_occupancy_grid_radius_search_top_tb;
  import vogrs_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    hits_pending;
  int                    cycle_cnt;
  bit                    send_gaps;
  bit                    stall_on;

  voxel_occupancy_grid_radius_search_top DUT (.*);

  voxel_grid_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack(int x, int y, int z, int v, int r, int m);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[5:0] = x[5:0];
    d[11:6] = y[5:0];
    d[17:12] = z[5:0];
    d[25:18] = v[7:0];
    d[31:26] = r[5:0];
    d[38:32] = m[6:0];
    return d;
  endfunction

  task automatic send(kind_t k, logic [IN_DATA_W-1:0] d);
    in_tvalid <= 1'b1;
    in_tuser <= k;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (hits_pending != 0 || !in_tready);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_grid(int sx, int sy, int sz, int thr, int cmax, int cmin);
    write_reg(CFG_SIZE_X, sx);
    write_reg(CFG_SIZE_Y, sy);
    write_reg(CFG_SIZE_Z, sz);
    write_reg(CFG_OCC_THR, thr);
    write_reg(CFG_CELL_MAX, cmax);
    write_reg(CFG_CELL_MIN, cmin);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item(int dim);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55)
      send(KIND_UPDATE, pack($urandom_range(0, (sel < 50) ? dim - 1 : 63),
                             $urandom_range(0, dim - 1), $urandom_range(0, dim - 1),
                             $urandom_range(0, 255), 0, $urandom_range(0, 127)));
    else if (sel < 97)
      send(KIND_SEARCH, pack($urandom_range(0, 63), $urandom_range(0, dim + 1),
                             $urandom_range(0, dim + 1), $urandom_range(0, 255),
                             (sel < 94) ? $urandom_range(0, 6) : 63,
                             ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 127)));
    else
      send(kind_t'(2'd3), pack($urandom_range(0, 63), 0, 0, $urandom_range(0, 255), 5, 0));
  endtask

  initial begin
    int dim;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= KIND_UPDATE;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_SIZE_X;
    cfg_wdata <= '0;
    cycle_cnt <= 0;
    send_gaps = 1;
    stall_on = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    set_grid(4, 4, 4, 0, 127, -127);
    send(KIND_UPDATE, pack(0, 0, 0, -100, 0, 0));
    send(KIND_UPDATE, pack(3, 3, 3, -127, 0, 0));
    send(KIND_UPDATE, pack(3, 3, 3, -127, 0, 0));
    send(KIND_UPDATE, pack(1, 0, 0, 127, 0, 0));
    send(KIND_UPDATE, pack(1, 0, 0, 5, 0, 0));
    send(KIND_UPDATE, pack(2, 1, 0, 0, 0, 0));
    send(KIND_UPDATE, pack(4, 0, 0, -50, 0, 0));
    send(KIND_UPDATE, pack(63, 63, 63, -50, 0, 0));
    send(KIND_SEARCH, pack(0, 0, 0, 0, 0, 0));
    send(KIND_SEARCH, pack(63, 63, 63, -1, 63, 0));
    send(KIND_SEARCH, pack(0, 0, 0, 0, 63, 1));
    send(kind_t'(2'd3), pack(0, 0, 0, -128, 63, 0));
    send(KIND_FILL, pack(0, 0, 0, -128, 0, 0));
    send(KIND_SEARCH, pack(2, 2, 2, 0, 63, 0));
    send(KIND_SEARCH, pack(1, 2, 3, 0, 2, 127));
    settle();
    set_grid(5, 5, 5, 127, 0, 0);
    send(KIND_SEARCH, pack(2, 2, 2, 0, 63, 64));
    send(KIND_UPDATE, pack(0, 0, 0, 100, 0, 0));
    send(KIND_UPDATE, pack(1, 1, 1, -100, 0, 0));
    send(KIND_SEARCH, pack(0, 0, 0, 0, 1, 0));
    settle();
    set_grid(0, 63, 0, -127, 127, -127);
    send(KIND_SEARCH, pack(10, 40, 63, 0, 63, 0));
    send(KIND_FILL, pack(0, 0, 0, 127, 0, 0));
    send(KIND_SEARCH, pack(0, 0, 0, 0, 63, 0));
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      dim = $urandom_range(2, 6);
      send_gaps = (phase != 2);
      set_grid(dim, $urandom_range(1, dim), $urandom_range(1, dim),
               $urandom_range(0, 1) ? $urandom_range(0, 40) : -$urandom_range(0, 127),
               $urandom_range(0, 127), -$urandom_range(0, 127));
      if (phase % 2 == 0) send(KIND_FILL, pack(0, 0, 0, $urandom_range(0, 255), 0, 0));
      for (int i = 0; i < 30; i++) begin
        if (phase == 5) stall_on = (i < 10);
        if (phase == 5) send_gaps = (i < 10);
        if (phase == 1 && i == 15) settle();
        random_item(dim);
      end
      settle();
    end

    set_grid(32, 32, 32, 1, 127, -127);
    send(KIND_SEARCH, pack(31, 31, 31, 0, 63, 0));
    settle();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
